@@ src/gtca_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package gtca_pkg;

  localparam int MAX_TILES_DEF = 256;

  localparam int CODE_W = 21;
  localparam int RAND_W = 16;
  localparam int REG_W  = 9;
  localparam int BYTE_W = 8;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // register indexes, one word apart
  localparam logic REG_TILES_PER_ROW = 1'b0;
  localparam logic REG_TILES_IN_USE  = 1'b1;

  localparam logic [REG_W-1:0] TILES_PER_ROW_RST = 9'd16;
  localparam logic [REG_W-1:0] TILES_IN_USE_RST  = 9'd256;

  typedef struct packed {
    logic [CODE_W-1:0] code_point;
    logic [RAND_W-1:0] random_value;
  } in_word_t;

  typedef struct packed {
    logic              hit;
    logic [BYTE_W-1:0] tile_index;
    logic [BYTE_W-1:0] tile_column;
    logic [BYTE_W-1:0] tile_row;
    logic              evicted_valid;
    logic [CODE_W-1:0] evicted_code;
  } out_word_t;

  // one tile entry as stored in memory
  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
  } tile_entry_t;

endpackage
`default_nettype wire

@@ src/gtca_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface gtca_in_if;
  import gtca_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gtca_out_if;
  import gtca_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/gtca_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gtca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/glyph_tile_cache_allocator_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Glyph tile cache allocator: maps character codes to atlas tiles.
// in_ch carries one word per request (code_point, random_value); out_ch
// returns one word per request (hit, tile index, column, row, evicted code).
// Both channels move a word on a clock edge with valid and ready high.
// The APB port writes tiles_per_row (0x0) and tiles_in_use (0x4); write it
// only while no request is in flight.
// One request is in work at a time. The tile table lives in one RAM and is
// scanned one entry per cycle. A miss on a full table adds random_value mod
// tiles_in_use and a victim read. Every request ends with a column/row
// division and an output state.
// After rst the RAM is cleared, one entry per cycle; in_ch.ready stays low
// during that pass while APB writes are taken.
// A request may be accepted while a finished word still waits on out_ch;
// the next word is held in its last state until the receiver takes the first.
module glyph_tile_cache_allocator_unit #(
  parameter int MAX_TILES = gtca_pkg::MAX_TILES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  gtca_in_if.sink                           in_ch,
  gtca_out_if.source                        out_ch,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [gtca_pkg::PADDR_W-1:0] paddr,
  input  wire logic [gtca_pkg::PDATA_W-1:0] pwdata,
  output logic      [gtca_pkg::PDATA_W-1:0] prdata,
  output logic                              pready
);
  import gtca_pkg::*;

  localparam int IW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int PW = $clog2(MAX_TILES + 1);
  localparam int DW = RAND_W;
  localparam int ENT_W = $bits(tile_entry_t);
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_TILES - 1);
  localparam logic [4:0] LAST_STEP = 5'(DW - 1);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_SCAN  = 8'b0000_0100,
    S_MOD   = 8'b0000_1000,
    S_VREAD = 8'b0001_0000,
    S_VCHK  = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state;

  logic [REG_W-1:0] tiles_per_row;
  logic [REG_W-1:0] tiles_in_use;

  // APB register file
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tiles_per_row <= TILES_PER_ROW_RST;
      tiles_in_use  <= TILES_IN_USE_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_TILES_PER_ROW: tiles_per_row <= pwdata[REG_W-1:0];
        REG_TILES_IN_USE:  tiles_in_use  <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TILES_PER_ROW: prdata = PDATA_W'(tiles_per_row);
      REG_TILES_IN_USE:  prdata = PDATA_W'(tiles_in_use);
      default:           prdata = '0;
    endcase
  end

  // effective register values
  logic [REG_W-1:0] use_eff;
  logic [REG_W-1:0] tpr_eff;
  logic [REG_W-1:0] use_nz;

  assign use_nz  = (tiles_in_use == '0) ? REG_W'(1) : tiles_in_use;
  assign use_eff = (32'(use_nz) > MAX_TILES) ? REG_W'(MAX_TILES) : use_nz;
  assign tpr_eff = (tiles_per_row == '0) ? REG_W'(1) : tiles_per_row;

  // request registers
  logic [CODE_W-1:0] code_r;
  logic [RAND_W-1:0] rnd_r;
  logic [PW-1:0]     filled;

  // scan pointers
  logic [PW-1:0] issue_ptr;
  logic [IW-1:0] chk_ptr;
  logic          chk_vld;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic [IW-1:0] clr_ptr;

  // result registers
  logic [IW-1:0]     idx;
  logic              hit_r;
  logic              ev_valid_r;
  logic [CODE_W-1:0] ev_code_r;

  // shared restoring divider
  logic [DW-1:0]    dvd;
  logic [REG_W-1:0] dsr;
  logic [REG_W-1:0] rem;
  logic [4:0]       step;
  logic [REG_W:0]   rem_sh;
  logic [REG_W:0]   rem_sub;
  logic             qbit;
  logic [REG_W-1:0] rem_step;
  logic [DW-1:0]    dvd_step;

  assign rem_sh   = {rem, dvd[DW-1]};
  assign rem_sub  = rem_sh - {1'b0, dsr};
  assign qbit     = (rem_sh >= {1'b0, dsr});
  assign rem_step = qbit ? rem_sub[REG_W-1:0] : rem_sh[REG_W-1:0];
  assign dvd_step = {dvd[DW-2:0], qbit};

  // memory
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  tile_entry_t       ram_wdata;
  logic [IW-1:0]     ram_raddr;
  logic [ENT_W-1:0]  ram_rdata;
  tile_entry_t       ent;

  assign ent = tile_entry_t'(ram_rdata);

  gtca_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_TILES)
  ) u_tile_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // scan decode of the entry read back this cycle
  logic          ent_hit;
  logic          ent_free;
  logic          scan_last;
  logic          free_any;
  logic [IW-1:0] free_sel;
  logic          take_free;

  assign ent_hit   = chk_vld && ent.valid && (ent.code == code_r);
  assign ent_free  = chk_vld && !ent.valid && (32'(chk_ptr) < 32'(use_eff));
  assign scan_last = chk_vld && (chk_ptr == LAST_IDX);
  assign free_any  = free_found || ent_free;
  assign free_sel  = free_found ? free_idx : chk_ptr;
  assign take_free = free_any && (32'(filled) < 32'(use_eff));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = '{valid: 1'b1, code: code_r};
    ram_raddr = (state == S_SCAN) ? issue_ptr[IW-1:0] : idx;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_ptr;
        ram_wdata = '0;
      end
      S_SCAN: begin
        if (scan_last && !ent_hit && take_free) begin
          ram_we    = 1'b1;
          ram_waddr = free_sel;
        end
      end
      S_VCHK: begin
        ram_we = 1'b1;
      end
      default: ;
    endcase
  end

  assign in_ch.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_ptr    <= '0;
      filled     <= '0;
      issue_ptr  <= '0;
      chk_vld    <= 1'b0;
      free_found <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_ch.valid || out_ch.ready)) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_ptr <= clr_ptr + 1'b1;
          if (clr_ptr == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            code_r     <= in_ch.data.code_point;
            rnd_r      <= in_ch.data.random_value;
            issue_ptr  <= '0;
            chk_vld    <= 1'b0;
            free_found <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          chk_ptr <= issue_ptr[IW-1:0];
          chk_vld <= (32'(issue_ptr) < MAX_TILES);
          if (32'(issue_ptr) < MAX_TILES) begin
            issue_ptr <= issue_ptr + 1'b1;
          end
          if (ent_free && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= chk_ptr;
          end
          if (ent_hit) begin
            hit_r      <= 1'b1;
            ev_valid_r <= 1'b0;
            ev_code_r  <= '0;
            idx        <= chk_ptr;
            dvd        <= DW'(chk_ptr);
            dsr        <= tpr_eff;
            rem        <= '0;
            step       <= '0;
            state      <= S_DIV;
          end else if (scan_last) begin
            hit_r      <= 1'b0;
            ev_valid_r <= 1'b0;
            ev_code_r  <= '0;
            rem        <= '0;
            step       <= '0;
            if (take_free) begin
              // place into the lowest free tile
              idx    <= free_sel;
              filled <= filled + 1'b1;
              dvd    <= DW'(free_sel);
              dsr    <= tpr_eff;
              state  <= S_DIV;
            end else begin
              dvd   <= rnd_r;
              dsr   <= use_eff;
              state <= S_MOD;
            end
          end
        end
        S_MOD: begin
          rem  <= rem_step;
          dvd  <= dvd_step;
          step <= step + 1'b1;
          if (step == LAST_STEP) begin
            idx   <= IW'(rem_step);
            state <= S_VREAD;
          end
        end
        S_VREAD: begin
          state <= S_VCHK;
        end
        S_VCHK: begin
          ev_valid_r <= ent.valid;
          ev_code_r  <= ent.valid ? ent.code : '0;
          if (!ent.valid && (32'(filled) < MAX_TILES)) begin
            filled <= filled + 1'b1;
          end
          dvd   <= DW'(idx);
          dsr   <= tpr_eff;
          rem   <= '0;
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem  <= rem_step;
          dvd  <= dvd_step;
          step <= step + 1'b1;
          if (step == LAST_STEP) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output slot is free
          if (!out_ch.valid || out_ch.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_ch.valid || out_ch.ready)) begin
      out_ch.data.hit           <= hit_r;
      out_ch.data.tile_index    <= BYTE_W'(idx);
      out_ch.data.tile_column   <= BYTE_W'(rem);
      out_ch.data.tile_row      <= BYTE_W'(dvd);
      out_ch.data.evicted_valid <= ev_valid_r;
      out_ch.data.evicted_code  <= ev_code_r;
    end
  end

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import gtca_pkg::*;

  localparam int TILES = MAX_TILES_DEF;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  gtca_in_if  in_ch ();
  gtca_out_if out_ch ();

  glyph_tile_cache_allocator_unit dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // tile table as the block should hold it
  logic [CODE_W-1:0] tile_code_mem [TILES];
  bit                tile_used [TILES];
  int                fill_count = 0;
  logic [REG_W-1:0]  per_row = TILES_PER_ROW_RST;
  logic [REG_W-1:0]  in_use_reg = TILES_IN_USE_RST;

  in_word_t          lookups_to_send [$];
  out_word_t         tile_words_due [$];
  logic [CODE_W-1:0] seen_codes [$];

  int errors = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  bit in_fired = 1'b0;

  task automatic log_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    errors++;
  endtask

  function automatic void place_glyph(input in_word_t w);
    int        use_n;
    int        tpr;
    int        idx;
    int        i;
    bit        found;
    bit        placed;
    out_word_t r;
    use_n = (in_use_reg == 0) ? 1 : ((in_use_reg > TILES) ? TILES : int'(in_use_reg));
    tpr = (per_row == 0) ? 1 : int'(per_row);
    idx = 0;
    found = 1'b0;
    placed = 1'b0;
    r = '0;
    for (i = 0; i < TILES; i++) begin
      if (!found && tile_used[i] && tile_code_mem[i] == w.code_point) begin
        idx = i;
        found = 1'b1;
      end
    end
    if (found) begin
      r.hit = 1'b1;
    end else begin
      if (fill_count < use_n) begin
        for (i = 0; i < use_n; i++) begin
          if (!placed && !tile_used[i]) begin
            idx = i;
            placed = 1'b1;
          end
        end
      end
      // no free tile: pick a victim
      if (!placed) begin
        idx = int'(w.random_value) % use_n;
        if (tile_used[idx]) begin
          r.evicted_valid = 1'b1;
          r.evicted_code = tile_code_mem[idx];
        end
      end
      if (!tile_used[idx] && fill_count < TILES) fill_count++;
      tile_used[idx] = 1'b1;
      tile_code_mem[idx] = w.code_point;
    end
    r.tile_index = BYTE_W'(idx);
    r.tile_column = BYTE_W'(idx % tpr);
    r.tile_row = BYTE_W'(idx / tpr);
    tile_words_due.push_back(r);
  endfunction

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      log_mismatch($sformatf("%s mismatch: got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  task automatic check_tile_word(input out_word_t got);
    out_word_t want;
    if (tile_words_due.size() == 0) begin
      log_mismatch($sformatf("unexpected word 0x%0h", got));
    end else begin
      want = tile_words_due.pop_front();
      compare_field("hit", 32'(got.hit), 32'(want.hit));
      compare_field("tile_index", 32'(got.tile_index), 32'(want.tile_index));
      compare_field("tile_column", 32'(got.tile_column), 32'(want.tile_column));
      compare_field("tile_row", 32'(got.tile_row), 32'(want.tile_row));
      compare_field("evicted_valid", 32'(got.evicted_valid), 32'(want.evicted_valid));
      compare_field("evicted_code", 32'(got.evicted_code), 32'(want.evicted_code));
    end
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    in_fired = 1'b0;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        in_fired = 1'b1;
        place_glyph(in_ch.data);
      end
      if (out_ch.valid && out_ch.ready) check_tile_word(out_ch.data);
    end
  end

  // request driver: hold a word until taken, then advance
  always @(negedge clk) begin
    if (!rst && (!in_ch.valid || in_fired)) begin
      if (lookups_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        in_ch.data <= lookups_to_send.pop_front();
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst || hold_left != 0) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(negedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  task automatic write_reg(input logic which, input logic [REG_W-1:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {which, 2'b00};
    pwdata = {(PDATA_W-REG_W)'($urandom), value};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (which == REG_TILES_PER_ROW) per_row = value;
    else in_use_reg = value;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic drain();
    @(posedge clk);
    while (lookups_to_send.size() != 0 || in_ch.valid || tile_words_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic enter_phase(input logic [REG_W-1:0] tpr, input logic [REG_W-1:0] tiu,
                             input idle_mode_t mode);
    drain();
    write_reg(REG_TILES_PER_ROW, tpr);
    write_reg(REG_TILES_IN_USE, tiu);
    case (mode)
      IDLE_NONE: begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      IDLE_SEND: begin
        send_gap_pct = 46;
        recv_stall_pct = 0;
      end
      IDLE_RECV: begin
        send_gap_pct = 0;
        recv_stall_pct = 46;
      end
      default: begin
        send_gap_pct = 17;
        recv_stall_pct = 17;
      end
    endcase
  endtask

  task automatic send_lookup(input logic [CODE_W-1:0] code, input logic [RAND_W-1:0] rnd);
    in_word_t w;
    w.code_point = code;
    w.random_value = rnd;
    lookups_to_send.push_back(w);
    seen_codes.push_back(code);
    if (seen_codes.size() > 400) void'(seen_codes.pop_front());
  endtask

  // mix of repeats (mostly hits), fresh codes (misses) and edge codes
  task automatic queue_random(input int count, input int fresh_pct);
    int                n;
    int                sel;
    logic [CODE_W-1:0] code;
    logic [RAND_W-1:0] rnd;
    for (n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < fresh_pct || seen_codes.size() == 0) begin
        code = CODE_W'($urandom);
      end else if (sel < fresh_pct + 8) begin
        case ($urandom_range(3))
          0: code = '0;
          1: code = '1;
          2: code = CODE_W'($urandom_range(15));
          default: code = CODE_W'(21'h1FFFF0 + $urandom_range(15));
        endcase
      end else begin
        code = seen_codes[$urandom_range(seen_codes.size() - 1)];
      end
      case ($urandom_range(9))
        0: rnd = '0;
        1: rnd = '1;
        default: rnd = RAND_W'($urandom);
      endcase
      send_lookup(code, rnd);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // zero row width and zero tiles in use: single tile, evict in place
    enter_phase(9'd0, 9'd0, IDLE_NONE);
    send_lookup(21'h000000, 16'h0000);
    send_lookup(21'h000000, 16'hFFFF);
    send_lookup(21'h1FFFFF, 16'hFFFF);
    send_lookup(21'h1FFFFF, 16'h0000);
    send_lookup(21'h155555, 16'hAAAA);
    send_lookup(21'h0AAAAA, 16'h5555);

    // oversized registers: clamp to the full table, widest row
    enter_phase(9'd511, 9'd511, IDLE_NONE);
    send_lookup(21'h0AAAAA, 16'h0000);
    send_lookup(21'h000001, 16'hFFFF);
    send_lookup(21'h000002, 16'h0000);
    send_lookup(21'h000003, 16'h1234);
    send_lookup(21'h1FFFFE, 16'h8000);

    enter_phase(9'd1, 9'd256, IDLE_NONE);
    send_lookup(21'h000005, 16'h0000);
    send_lookup(21'h000002, 16'h0000);
    send_lookup(21'h1FFFFE, 16'h0000);

    // hit above tiles in use, then evict tile zero
    enter_phase(9'd256, 9'd1, IDLE_NONE);
    send_lookup(21'h000003, 16'hFFFF);
    send_lookup(21'h000006, 16'hFFFF);
    send_lookup(21'h000007, 16'h0000);

    enter_phase(9'd7, 9'd3, IDLE_NONE);
    send_lookup(21'h000008, 16'hFFFF);
    send_lookup(21'h000009, 16'h0002);
    send_lookup(21'h000001, 16'h0005);

    enter_phase(9'd16, 9'd256, IDLE_NONE);
    queue_random(320, 70);

    enter_phase(9'd256, 9'd256, IDLE_SEND);
    queue_random(300, 40);

    // receiver holds off long enough to back up the input
    enter_phase(9'd5, 9'd37, IDLE_RECV);
    @(posedge clk);
    hold_left = 1500;
    queue_random(250, 30);

    enter_phase(9'd1, 9'd1, IDLE_BOTH);
    queue_random(150, 50);

    enter_phase(9'd0, 9'd511, IDLE_BOTH);
    queue_random(200, 35);

    enter_phase(9'd255, 9'd200, IDLE_NONE);
    queue_random(180, 30);

    drain();
    repeat (TILES + 64) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
